// ----- rtl/ass_pkg.sv -----
// Package with shared types, constants and the alpha table function.
`default_nettype none
package ass_pkg;

  localparam int SpikeSlotsDefault   = 64;
  localparam int AlphaEntriesDefault = 2048;

  localparam int TimeW   = 32;
  localparam int WeightW = 24;
  localparam int CfgW    = 16;
  localparam int CurW    = 48;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  localparam logic [2:0] REG_TAU_E  = 3'd0;
  localparam logic [2:0] REG_TAU_I  = 3'd1;
  localparam logic [2:0] REG_GMAX_E = 3'd2;
  localparam logic [2:0] REG_GMAX_I = 3'd3;
  localparam logic [2:0] REG_REV_E  = 3'd4;
  localparam logic [2:0] REG_REV_I  = 3'd5;

  localparam logic [63:0] E_Q28 = 64'd729683222;

  // Input item fields.
  typedef struct packed {
    logic signed [15:0] vm_last;
    logic signed [15:0] vm_first;
    logic               list_end;
    logic [15:0]        spike_weight;
    logic [15:0]        delay;
    logic [31:0]        event_time;
    logic               synapse;
    logic [1:0]         cmd;
  } in_item_t;

  // Result item fields.
  typedef struct packed {
    logic        store_full;
    logic [15:0] added_count;
    logic [7:0]  kept_count;
    logic signed [47:0] current_last;
    logic signed [47:0] current_first;
  } out_item_t;

  // Configuration values seen by the engine.
  typedef struct packed {
    logic [15:0] tau_e;
    logic [15:0] tau_i;
    logic [15:0] gmax_e;
    logic [15:0] gmax_i;
    logic signed [15:0] rev_e;
    logic signed [15:0] rev_i;
  } cfg_t;

  // Alpha entry k in unsigned Q16, elaborated as a constant table.
  function automatic logic [16:0] alpha_entry(input int k, input int entries);
    logic [63:0] x, term, e, p, v, a;
    int n;
    x = (64'd8 << 32) / 64'(entries);
    term = 64'd1 << 32;
    e = term;
    for (n = 1; n <= 10; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) e = e - term; else e = e + term;
    end
    p = 64'd1 << 32;
    for (n = 0; n < k; n++) p = (p * e) >> 32;
    v = p * 64'(k) * 64'd8 / 64'(entries);
    a = (v * E_Q28 + (64'd1 << 43)) >> 44;
    return (a > 64'd65536) ? 17'd65536 : a[16:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ass_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module ass_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a write to the same address returns the old contents.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/ass_alpha_rom.sv -----
// Registered alpha lookup table.
`default_nettype none
module ass_alpha_rom #(
  parameter int ENTRIES = ass_pkg::AlphaEntriesDefault
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(ENTRIES)-1:0] idx,
  output logic [16:0]                     alpha
);
  import ass_pkg::*;

  logic [16:0] rom [ENTRIES];

  // Table contents are elaboration constants.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
    assign rom[k] = alpha_entry(k, ENTRIES);
  end

  always_ff @(posedge clk) begin
    alpha <= rom[idx];
  end
endmodule
`default_nettype wire

// ----- rtl/ass_engine.sv -----
// Command sequencer: walks the slot memories for add, update and evaluate.
`default_nettype none
module ass_engine #(
  parameter int SPIKE_SLOTS   = ass_pkg::SpikeSlotsDefault,
  parameter int ALPHA_ENTRIES = ass_pkg::AlphaEntriesDefault
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ass_pkg::cfg_t    cfg,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ass_pkg::in_item_t item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output ass_pkg::out_item_t    res
);
  import ass_pkg::*;

  localparam int TotalSlots = 2 * SPIKE_SLOTS;
  localparam int AW = $clog2(TotalSlots);
  localparam int SW = $clog2(SPIKE_SLOTS);
  localparam int IW = $clog2(ALPHA_ENTRIES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADD  = 4'd1;
  localparam logic [3:0] ST_ADDW = 4'd2;
  localparam logic [3:0] ST_UPD  = 4'd3;
  localparam logic [3:0] ST_EVAL = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_MUL3 = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;
  localparam logic [3:0] ST_ROM  = 4'd10;

  logic [3:0] state_r, state_nxt;
  in_item_t item_r;
  logic [AW:0] ptr_r;
  logic [TotalSlots-1:0] valid_r, pub_r;
  logic [15:0] added_r;
  logic [7:0] kept_r;
  logic [31:0] t_r;
  logic [AW-1:0] free_r;
  logic free_ok_r;
  logic [AW-1:0] hit_r;
  logic hit_ok_r;
  logic rd_pend_r;
  logic [AW-1:0] rd_addr_r;
  logic signed [63:0] sum0_r, sum1_r;
  out_item_t res_r;
  logic res_valid_r;
  // Divider and multiply chain state.
  logic [47:0] num_r;
  logic [47:0] rem_r;
  logic [47:0] quo_r;
  logic [5:0]  dcnt_r;
  logic [23:0] w_r;
  logic [32:0] g_r;
  logic [56:0] gw_r;
  logic [16:0] adv_r;
  logic        neg_r;
  logic [73:0] term_r;

  // Memories.
  logic [AW-1:0]     mem_addr;
  logic [31:0]       time_wd, time_rd;
  logic [23:0]       live_wd, live_rd;
  logic [23:0]       pub_wd, pub_rd;
  logic              time_we, live_we, pubw_we;

  ass_ram #(.WIDTH(32), .DEPTH(TotalSlots)) u_time (
    .clk(clk), .we(time_we), .addr(mem_addr), .wdata(time_wd), .rdata(time_rd));
  ass_ram #(.WIDTH(24), .DEPTH(TotalSlots)) u_live (
    .clk(clk), .we(live_we), .addr(mem_addr), .wdata(live_wd), .rdata(live_rd));
  ass_ram #(.WIDTH(24), .DEPTH(TotalSlots)) u_pubw (
    .clk(clk), .we(pubw_we), .addr(mem_addr), .wdata(pub_wd), .rdata(pub_rd));

  logic [IW-1:0] rom_idx;
  logic [16:0] alpha;
  ass_alpha_rom #(.ENTRIES(ALPHA_ENTRIES)) u_rom (.clk(clk), .idx(rom_idx), .alpha(alpha));
  assign rom_idx = quo_r[IW-1:0];

  // Per-synapse configuration for the slot being processed.
  logic cur_syn;
  logic rd_syn;
  logic [15:0] tau_raw, tau_eff, gmax;
  logic signed [15:0] rev;
  logic signed [16:0] dv;
  logic [32:0] tsum;
  logic [AW-1:0] base;
  logic [47:0] rem_sh;
  logic [47:0] div_d;

  // Slots of the inhibitory synapse sit above the excitatory ones.
  assign rd_syn = (rd_addr_r >= AW'(SPIKE_SLOTS));
  assign cur_syn = (state_r == ST_ADD || state_r == ST_ADDW) ? item_r.synapse : rd_syn;
  assign tau_raw = cur_syn ? cfg.tau_i : cfg.tau_e;
  assign tau_eff = (tau_raw == 16'd0) ? 16'd1 : tau_raw;
  assign gmax = cur_syn ? cfg.gmax_i : cfg.gmax_e;
  assign rev = cur_syn ? cfg.rev_i : cfg.rev_e;
  assign dv = cur_syn ? (17'(item_r.vm_last) - 17'(rev))
                      : (17'(item_r.vm_first) - 17'(rev));
  assign tsum = 33'(item.event_time) + 33'(item.delay);
  assign base = item_r.synapse ? AW'(SPIKE_SLOTS) : '0;
  // Restoring division step: divisor is 8*tau.
  assign div_d = 48'(tau_eff) << 3;
  assign rem_sh = {rem_r[46:0], num_r[47]};

  assign item_ready = (state_r == ST_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res = res_r;

  logic [31:0] now;
  logic [31:0] el;
  assign now = item_r.event_time;
  assign el = now - time_rd;

  always_comb begin
    state_nxt = state_r;
    mem_addr = ptr_r[AW-1:0];
    time_we = 1'b0; live_we = 1'b0; pubw_we = 1'b0;
    time_wd = t_r; live_wd = 24'(item_r.spike_weight); pub_wd = live_rd;
    unique case (state_r)
      ST_ADD: begin
        // Once the scan is over, read the slot that will be written back.
        if (hit_ok_r || ptr_r[SW:0] >= (SW+1)'(SPIKE_SLOTS))
          mem_addr = hit_ok_r ? hit_r : free_r;
        else mem_addr = base + AW'(ptr_r[SW-1:0]);
      end
      ST_ADDW: begin
        mem_addr = hit_ok_r ? hit_r : free_r;
        time_we = !hit_ok_r;
        live_we = 1'b1;
        if (hit_ok_r) live_wd = ((25'(live_rd) + 25'(item_r.spike_weight)) > 25'hFFFFFF)
                                ? 24'hFFFFFF : 24'(live_rd + 24'(item_r.spike_weight));
      end
      ST_UPD: begin
        mem_addr = ptr_r[AW-1:0];
        if (rd_pend_r) begin
          mem_addr = rd_addr_r;
          pubw_we = 1'b1;
        end
      end
      default: mem_addr = ptr_r[AW-1:0];
    endcase
    if (state_r == ST_UPD && rd_pend_r) begin
      // Update writes the published weight when the slot stays valid.
      pubw_we = valid_r[rd_addr_r] &&
                !(time_rd <= now && 48'(el) > 48'(tau_eff) * 48'd6);
    end
  end

  logic prune;
  assign prune = valid_r[rd_addr_r] && time_rd <= now && 48'(el) > 48'(tau_eff) * 48'd6;

  function automatic logic [47:0] sat(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFFFFFF) return 48'h7FFFFFFFFFFF;
    if (v < -64'sh800000000000) return 48'h800000000000;
    return v[47:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      pub_r <= '0;
      added_r <= '0;
      res_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (item_valid && item_ready) begin
            item_r <= item;
            t_r <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
            ptr_r <= '0;
            hit_ok_r <= 1'b0;
            free_ok_r <= 1'b0;
            rd_pend_r <= 1'b0;
            kept_r <= '0;
            sum0_r <= '0;
            sum1_r <= '0;
            res_r <= '0;
            unique case (item.cmd)
              CMD_ADD:    state_r <= ST_ADD;
              CMD_UPDATE: state_r <= ST_UPD;
              CMD_EVAL:   state_r <= ST_EVAL;
              default: begin
                res_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_ADD: begin
          // Scan synapse slots; compare read data in the next cycle.
          if (rd_pend_r && !hit_ok_r) begin
            if (valid_r[rd_addr_r] && time_rd == t_r) begin
              hit_ok_r <= 1'b1; hit_r <= rd_addr_r;
            end else if (!valid_r[rd_addr_r] && !free_ok_r) begin
              free_ok_r <= 1'b1; free_r <= rd_addr_r;
            end
          end
          if (ptr_r[SW:0] < (SW+1)'(SPIKE_SLOTS) && !(rd_pend_r && valid_r[rd_addr_r]
              && time_rd == t_r) && !hit_ok_r) begin
            rd_addr_r <= base + AW'(ptr_r[SW-1:0]);
            rd_pend_r <= 1'b1;
            ptr_r <= ptr_r + 1'b1;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else begin
            if (!hit_ok_r && !free_ok_r) begin
              res_r.store_full <= 1'b1;
              res_valid_r <= 1'b1;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_ADDW;
            end
          end
        end
        ST_ADDW: begin
          if (!hit_ok_r) valid_r[free_r] <= 1'b1;
          if (added_r != 16'hFFFF) added_r <= added_r + 1'b1;
          res_valid_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        ST_UPD: begin
          if (rd_pend_r) begin
            valid_r[rd_addr_r] <= valid_r[rd_addr_r] && !prune;
            pub_r[rd_addr_r] <= valid_r[rd_addr_r] && !prune;
            if (valid_r[rd_addr_r] && !prune && kept_r != 8'hFF) kept_r <= kept_r + 1'b1;
            rd_pend_r <= 1'b0;
            ptr_r <= ptr_r + 1'b1;
            if (ptr_r == (AW+1)'(TotalSlots - 1)) begin
              res_r.kept_count <= (valid_r[rd_addr_r] && !prune && kept_r != 8'hFF)
                                  ? kept_r + 1'b1 : kept_r;
              res_r.added_count <= added_r;
              added_r <= '0;
              res_valid_r <= 1'b1;
              state_r <= ST_IDLE;
            end
          end else begin
            rd_addr_r <= ptr_r[AW-1:0];
            rd_pend_r <= 1'b1;
          end
        end
        ST_EVAL: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            w_r <= pub_rd;
            if (pub_r[rd_addr_r] && time_rd <= now) begin
              num_r <= 48'(el) * 48'(ALPHA_ENTRIES);
              rem_r <= '0;
              dcnt_r <= '0;
              state_r <= ST_DIV;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end else if (ptr_r == (AW+1)'(TotalSlots)) begin
            res_r.current_first <= sat(sum0_r);
            res_r.current_last <= sat(sum1_r);
            res_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            rd_addr_r <= ptr_r[AW-1:0];
            rd_pend_r <= 1'b1;
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle.
          num_r <= {num_r[46:0], 1'b0};
          if (rem_sh >= div_d) begin
            rem_r <= rem_sh - div_d;
            quo_r <= {quo_r[46:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[46:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'd47) state_r <= ST_ROM;
        end
        ST_ROM: begin
          if (quo_r >= 48'(ALPHA_ENTRIES)) begin
            ptr_r <= ptr_r + 1'b1;
            state_r <= ST_EVAL;
          end else begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          g_r <= 33'((34'(gmax) * 34'(alpha)) >> 16);
          adv_r <= dv[16] ? 17'(-dv) : 17'(dv);
          neg_r <= dv[16];
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          gw_r <= 57'(g_r) * 57'(w_r);
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          term_r <= 74'(gw_r) * 74'(adv_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (rd_syn) sum1_r <= neg_r ? sum1_r - 64'(term_r >> 8)
                                      : sum1_r + 64'(term_r >> 8);
          else sum0_r <= neg_r ? sum0_r - 64'(term_r >> 8) : sum0_r + 64'(term_r >> 8);
          ptr_r <= ptr_r + 1'b1;
          state_r <= ST_EVAL;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A result is never raised straight from the divider state.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(state_r) != ST_DIV) else $error("result from divider");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    item_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_pub_sub: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_UPD && state_r == ST_IDLE |-> pub_r == valid_r)
    else $error("snapshot mismatch");
endmodule
`default_nettype wire

// ----- rtl/alpha_synapse_spike_store.sv -----
// Top level of the alpha synapse spike store.
//
// Input stream in_*: one command per transaction (add, update, evaluate).
// Output stream out_*: exactly one result transaction per command.
// Configuration channel cfg_*: register index and 16-bit data; always ready.
// Add scans the chosen synapse's SPIKE_SLOTS entries of the time memory at
// one slot per cycle, stopping early at a matching time, then writes back.
// Update reads all 2*SPIKE_SLOTS slots one at a time, each handled before the next.
// Evaluate reads every slot in turn; a published, reached spike then
// passes through a bit-serial divider, the table read, three multiply
// stages and the accumulate, one slot at a time.
// One command is processed at a time; a new command is accepted once the
// previous result has been taken from the output register.
// Reset (synchronous, active low) clears valid and published flags, the
// added counter and reloads the configuration defaults; slot memories are
// not cleared. When out_tready is low the result holds and input stalls.
`default_nettype none
module alpha_synapse_spike_store #(
  parameter int SPIKE_SLOTS   = ass_pkg::SpikeSlotsDefault,
  parameter int ALPHA_ENTRIES = ass_pkg::AlphaEntriesDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd, synapse, event_time, delay, spike_weight, vm_first, vm_last, zero pad
  input  wire logic [103:0] in_tdata,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // current_first, current_last, kept_count, added_count, store_full, zero pad
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import ass_pkg::*;

  cfg_t cfg_r;
  in_item_t item;
  out_item_t res;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tau_e <= 16'd256;
      cfg_r.tau_i <= 16'd256;
      cfg_r.gmax_e <= 16'd10000;
      cfg_r.gmax_i <= 16'd25000;
      cfg_r.rev_e <= 16'sd17920;
      cfg_r.rev_i <= -16'sd19200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAU_E:  cfg_r.tau_e <= cfg_data;
        REG_TAU_I:  cfg_r.tau_i <= cfg_data;
        REG_GMAX_E: cfg_r.gmax_e <= cfg_data;
        REG_GMAX_I: cfg_r.gmax_i <= cfg_data;
        REG_REV_E:  cfg_r.rev_e <= cfg_data;
        REG_REV_I:  cfg_r.rev_i <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input item.
  assign item.cmd = in_tdata[1:0];
  assign item.synapse = in_tdata[2];
  assign item.event_time = in_tdata[34:3];
  assign item.delay = in_tdata[50:35];
  assign item.spike_weight = in_tdata[66:51];
  assign item.list_end = in_tlast;
  assign item.vm_first = in_tdata[82:67];
  assign item.vm_last = in_tdata[98:83];

  ass_engine #(.SPIKE_SLOTS(SPIKE_SLOTS), .ALPHA_ENTRIES(ALPHA_ENTRIES)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .item_valid(in_tvalid), .item_ready(in_tready), .item(item),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = {7'd0, res.store_full, res.added_count, res.kept_count,
                      res.current_last, res.current_first};
endmodule
`default_nettype wire
